// ===== rtl/core/cgts_pkg.sv =====
`timescale 1ns / 1ps
// cgts_pkg: shared types and constants for the cfl global time step unit
// no dependencies

package cgts_pkg;

  localparam int FracBits = 16;
  localparam int MinW     = FracBits + 1;
  localparam logic [MinW-1:0] OneFix = MinW'(1) << FracBits;

  // configuration register indexes
  localparam logic [1:0] RegGamma   = 2'd0;
  localparam logic [1:0] RegGammaM1 = 2'd1;
  localparam logic [1:0] RegCellW   = 2'd2;
  localparam logic [1:0] RegCourant = 2'd3;

  localparam logic [17:0] GammaRst   = 18'd91750;
  localparam logic [17:0] GammaM1Rst = 18'd26214;
  localparam logic [16:0] CellWRst   = 17'd655;
  localparam logic [17:0] CourantRst = 18'd52429;

  typedef struct packed {
    logic [17:0] gamma;
    logic [17:0] gamma_m1;
    logic [16:0] cell_w;
    logic [17:0] courant;
  } cfg_t;

  // one classified cell
  typedef struct packed {
    logic [30:0]        r;     // density when positive
    logic [31:0]        m;     // momentum magnitude
    logic signed [31:0] ene;
    logic               last;
    logic               bad;   // density not positive
  } item_t;

  typedef struct packed {
    logic            div_busy;
    logic            sqrt_busy;
    logic [MinW-1:0] min_val;
  } status_t;

endpackage

// ===== rtl/core/cgts_front.sv =====
`timescale 1ns / 1ps
// cgts_front: accepts cells and classifies them for the queue
// depends on cgts_pkg

module cgts_front import cgts_pkg::*; (
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [31:0] density_i,
  input  logic signed [31:0] momentum_i,
  input  logic signed [31:0] energy_i,
  input  logic               last_cell_i,
  input  logic               full_i,
  output logic               push_o,
  output item_t              item_o
);

  assign in_ready_o = !full_i;
  assign push_o     = in_valid_i && !full_i;

  always_comb begin
    item_o      = '0;
    item_o.r    = density_i[30:0];
    item_o.m    = momentum_i[31] ? 32'(-momentum_i) : 32'(momentum_i);
    item_o.ene  = energy_i;
    item_o.last = last_cell_i;
    // non-positive density
    item_o.bad  = density_i[31] || (density_i == 32'sd0);
  end

endmodule

// ===== rtl/core/cgts_fifo.sv =====
`timescale 1ns / 1ps
// cgts_fifo: two entry queue between front and back
// depends on cgts_pkg

module cgts_fifo import cgts_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  item_t      item_i,
  output logic       full_o,
  input  logic       pop_i,
  output logic       valid_o,
  output item_t      item_o,
  output logic [1:0] count_o
);

  item_t      mem_q [2];
  logic       wr_q, wr_d, rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;

  assign full_o  = cnt_q[1];
  assign valid_o = cnt_q != 2'd0;
  assign item_o  = mem_q[rd_q];
  assign count_o = cnt_q;

  always_comb begin
    wr_d  = wr_q ^ push_i;
    rd_d  = rd_q ^ (pop_i && valid_o);
    cnt_d = cnt_q + 2'(push_i) - 2'(pop_i && valid_o);
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

// ===== rtl/core/cgts_div.sv =====
`timescale 1ns / 1ps
// cgts_div: restoring divider, one quotient bit per cycle, 64 / 49 bits
// no dependencies

module cgts_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] dividend_i,
  input  logic [48:0] divisor_i,
  output logic        busy_o,
  output logic        done_o,
  output logic [63:0] quot_o
);

  logic [63:0] dvd_q, dvd_d;
  logic [48:0] dsr_q;
  logic [48:0] rem_q, rem_d;
  logic [49:0] rem_sh, rem_sub;
  logic [5:0]  cnt_q;
  logic        busy_q, done_q;
  logic        ge;

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quot_o = dvd_q;

  always_comb begin
    rem_sh  = {rem_q, dvd_q[63]};
    rem_sub = rem_sh - {1'b0, dsr_q};
    ge      = rem_sh >= {1'b0, dsr_q};
    rem_d   = ge ? rem_sub[48:0] : rem_sh[48:0];
    dvd_d   = {dvd_q[62:0], ge};
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      dsr_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      dvd_q <= dvd_d;
      rem_q <= rem_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == 6'd63);
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 6'd1;
        if (cnt_q == 6'd63) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

endmodule

// ===== rtl/core/cgts_sqrt.sv =====
`timescale 1ns / 1ps
// cgts_sqrt: digit by digit integer square root, one bit pair per cycle
// no dependencies

module cgts_sqrt (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [67:0] radicand_i,
  output logic        busy_o,
  output logic        done_o,
  output logic [33:0] root_o
);

  logic [67:0] x_q;
  logic [33:0] root_q;
  logic [35:0] rem_q, rem_d;
  logic [37:0] rem_sh, trial, rem_sub;
  logic [5:0]  cnt_q;
  logic        busy_q, done_q;
  logic        ge;

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign root_o = root_q;

  always_comb begin
    rem_sh  = {rem_q, x_q[67:66]};
    trial   = 38'({root_q, 2'b01});
    rem_sub = rem_sh - trial;
    ge      = rem_sh >= trial;
    rem_d   = ge ? rem_sub[35:0] : rem_sh[35:0];
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q    <= radicand_i;
      root_q <= '0;
      rem_q  <= '0;
    end else if (busy_q) begin
      x_q    <= {x_q[65:0], 2'b00};
      root_q <= {root_q[32:0], ge};
      rem_q  <= rem_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == 6'd33);
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 6'd1;
        if (cnt_q == 6'd33) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

endmodule

// ===== rtl/core/cgts_back.sv =====
`timescale 1ns / 1ps
// cgts_back: per cell sequencer, running minimum and result register
// depends on cgts_pkg, cgts_div, cgts_sqrt

module cgts_back import cgts_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cfg_t        cfg_i,
  input  logic        valid_i,
  input  item_t       item_i,
  output logic        pop_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [17:0] time_step_out_o,
  output logic        bad_cell_seen_o,
  output status_t     status_o
);

  localparam logic [3:0] StIdle  = 4'd0;
  localparam logic [3:0] StMsq   = 4'd1;
  localparam logic [3:0] StKin   = 4'd2;
  localparam logic [3:0] StKinW  = 4'd3;
  localparam logic [3:0] StPrs   = 4'd4;
  localparam logic [3:0] StPchk  = 4'd5;
  localparam logic [3:0] StUaW   = 4'd6;
  localparam logic [3:0] StGmp   = 4'd7;
  localparam logic [3:0] StSdiv  = 4'd8;
  localparam logic [3:0] StSdivW = 4'd9;
  localparam logic [3:0] StSqW   = 4'd10;
  localparam logic [3:0] StLoc   = 4'd11;
  localparam logic [3:0] StLocW  = 4'd12;
  localparam logic [3:0] StFin   = 4'd13;
  localparam logic [3:0] StMulo  = 4'd14;
  localparam logic [3:0] StEmit  = 4'd15;

  logic [3:0]      state_q, state_d;
  item_t           it_q, it_d;
  logic [63:0]     prod_q, prod_d;
  logic [30:0]     inner_q, inner_d;
  logic            pos_q, pos_d;
  logic [32:0]     p_q, p_d;
  logic [47:0]     uabs_q, uabs_d;
  logic [48:0]     d_q, d_d;
  logic [MinW-1:0] min_q, min_d;
  logic            bad_q, bad_d;
  logic            ov_q, ov_d;
  logic [17:0]     ots_q, ots_d;
  logic            obad_q, obad_d;

  logic        div_start, div_busy, div_done;
  logic [63:0] div_dvd, div_quot;
  logic [48:0] div_dsr;
  logic        sq_start, sq_busy, sq_done;
  logic [67:0] sq_x;
  logic [33:0] sq_root;
  logic [64:0] diff;
  logic [32:0] p_new;

  cgts_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dsr),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  cgts_sqrt u_sqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (sq_start),
    .radicand_i (sq_x),
    .busy_o     (sq_busy),
    .done_o     (sq_done),
    .root_o     (sq_root)
  );

  assign pop_o           = (state_q == StIdle) && valid_i;
  assign out_valid_o     = ov_q;
  assign time_step_out_o = ots_q;
  assign bad_cell_seen_o = obad_q;
  assign status_o        = '{div_busy: div_busy, sqrt_busy: sq_busy, min_val: min_q};

  always_comb begin
    state_d   = state_q;
    it_d      = it_q;
    prod_d    = prod_q;
    inner_d   = inner_q;
    pos_d     = pos_q;
    p_d       = p_q;
    uabs_d    = uabs_q;
    d_d       = d_q;
    min_d     = min_q;
    bad_d     = bad_q;
    ov_d      = ov_q && !out_ready_i;
    ots_d     = ots_q;
    obad_d    = obad_q;
    div_start = 1'b0;
    div_dvd   = prod_q;
    div_dsr   = 49'(it_q.r);
    sq_start  = 1'b0;
    sq_x      = {1'b0, div_quot[50:0], 16'b0};
    diff      = 65'($signed(it_q.ene)) - {1'b0, div_quot};
    p_new     = prod_q[48:16];

    case (state_q)
      StIdle: begin
        if (valid_i) begin
          it_d = item_i;
          if (item_i.bad) begin
            bad_d   = 1'b1;
            state_d = StFin;
          end else begin
            state_d = StMsq;
          end
        end
      end
      StMsq: begin
        prod_d  = 64'(it_q.m) * 64'(it_q.m);
        state_d = StKin;
      end
      StKin: begin
        // kinetic term m*m / (2 rho)
        div_start = 1'b1;
        div_dsr   = 49'({it_q.r, 1'b0});
        state_d   = StKinW;
      end
      StKinW: begin
        if (div_done) begin
          pos_d   = !diff[64] && (diff != 65'd0);
          inner_d = diff[30:0];
          state_d = StPrs;
        end
      end
      StPrs: begin
        prod_d  = 64'(49'(cfg_i.gamma_m1) * 49'(inner_q));
        state_d = StPchk;
      end
      StPchk: begin
        if (!pos_q || (p_new == 33'd0)) begin
          bad_d   = 1'b1;
          state_d = StFin;
        end else begin
          // velocity magnitude m / rho
          p_d       = p_new;
          div_start = 1'b1;
          div_dvd   = 64'({it_q.m, 16'b0});
          state_d   = StUaW;
        end
      end
      StUaW: begin
        if (div_done) begin
          uabs_d  = div_quot[47:0];
          state_d = StGmp;
        end
      end
      StGmp: begin
        prod_d  = 64'(51'(cfg_i.gamma) * 51'(p_q));
        state_d = StSdiv;
      end
      StSdiv: begin
        div_start = 1'b1;
        state_d   = StSdivW;
      end
      StSdivW: begin
        if (div_done) begin
          sq_start = 1'b1;
          state_d  = StSqW;
        end
      end
      StSqW: begin
        if (sq_done) begin
          d_d     = 49'(uabs_q) + 49'(sq_root);
          state_d = StLoc;
        end
      end
      StLoc: begin
        if (d_q == 49'd0) begin
          state_d = StFin;
        end else begin
          div_start = 1'b1;
          div_dvd   = 64'({cfg_i.cell_w, 16'b0});
          div_dsr   = d_q;
          state_d   = StLocW;
        end
      end
      StLocW: begin
        if (div_done) begin
          if (div_quot < 64'(min_q)) begin
            min_d = div_quot[MinW-1:0];
          end
          state_d = StFin;
        end
      end
      StFin: begin
        state_d = it_q.last ? StMulo : StIdle;
      end
      StMulo: begin
        prod_d  = 64'(35'(cfg_i.courant) * 35'(min_q));
        state_d = StEmit;
      end
      StEmit: begin
        if (!ov_q || out_ready_i) begin
          ov_d    = 1'b1;
          ots_d   = prod_q[33:16];
          obad_d  = bad_q;
          min_d   = OneFix;
          bad_d   = 1'b0;
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i) begin
    it_q    <= it_d;
    prod_q  <= prod_d;
    inner_q <= inner_d;
    pos_q   <= pos_d;
    p_q     <= p_d;
    uabs_q  <= uabs_d;
    d_q     <= d_d;
    ots_q   <= ots_d;
    obad_q  <= obad_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      min_q   <= OneFix;
      bad_q   <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      min_q   <= min_d;
      bad_q   <= bad_d;
      ov_q    <= ov_d;
    end
  end

endmodule

// ===== rtl/core/cfl_global_time_step_unit.sv =====
`timescale 1ns / 1ps
// cfl_global_time_step_unit: top level of the global cfl time step block
// depends on cgts_pkg, cgts_front, cgts_fifo, cgts_back
//
// channel  direction  handshake                  payload
// in       input      in_valid_i / in_ready_o    density, momentum, energy, last_cell
// out      output     out_valid_o / out_ready_i  time_step_out, bad_cell_seen
// cfg      input      cfg_we_i                   cfg_idx_i, cfg_data_i
//
// a good cell makes four passes through the shared 64 step divider, three if its
// wave speed is zero, and one 34 step square root pass in the back end; a cell
// with non-positive density goes straight to the finish state, one that fails on
// pressure after the kinetic division; a last cell then passes StMulo and StEmit to
// load the result register, and waits while a previous result still waits on out_ready_i
// the front takes transactions into a two entry queue while the back works
// reset clears the running minimum to 1.0, the bad flag and all handshakes

module cfl_global_time_step_unit import cgts_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [31:0] density_i,
  input  logic signed [31:0] momentum_i,
  input  logic signed [31:0] energy_i,
  input  logic               last_cell_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [17:0]        time_step_out_o,
  output logic               bad_cell_seen_o,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [17:0]        cfg_data_i
);

  cfg_t       cfg_q, cfg_d;
  logic       push, full, pop, q_valid;
  item_t      push_item, q_item;
  logic [1:0] q_count;
  status_t    status;

  // configuration registers; the user must write them only while idle, the block does not enforce it
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        RegGamma:   cfg_d.gamma    = cfg_data_i;
        RegGammaM1: cfg_d.gamma_m1 = cfg_data_i;
        RegCellW:   cfg_d.cell_w   = cfg_data_i[16:0];
        RegCourant: cfg_d.courant  = cfg_data_i;
        default:    cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{gamma: GammaRst, gamma_m1: GammaM1Rst,
                 cell_w: CellWRst, courant: CourantRst};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // front: take the transaction, classify density, fold momentum sign
  cgts_front u_front (
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .density_i   (density_i),
    .momentum_i  (momentum_i),
    .energy_i    (energy_i),
    .last_cell_i (last_cell_i),
    .full_i      (full),
    .push_o      (push),
    .item_o      (push_item)
  );

  // queue decouples acceptance from the long per cell sequence
  cgts_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .item_o  (q_item),
    .count_o (q_count)
  );

  // back: pressure, wave speed, local step, running minimum, result
  cgts_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg_q),
    .valid_i         (q_valid),
    .item_i          (q_item),
    .pop_o           (pop),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .time_step_out_o (time_step_out_o),
    .bad_cell_seen_o (bad_cell_seen_o),
    .status_o        (status)
  );

  // running minimum never climbs above its start value of 1.0
  a_min_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.min_val <= OneFix)
    else $error("running minimum above 1.0");

  // divider and square root are used strictly one after the other
  a_units_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(status.div_busy && status.sqrt_busy))
    else $error("divider and square root busy together");

  // queue occupancy stays within its two entries
  a_queue_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_count != 2'd3) && !(full && push))
    else $error("queue overflow");

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// tb: self-checking testbench for cfl_global_time_step_unit
// depends on cgts_pkg and the rtl of the block; a scoreboard class predicts each batch result

module tb import cgts_pkg::*;;

  localparam int          LongHold  = 3000;     // receiver hold-off, in cycles
  localparam int          DrainWait = 400;      // covers one good cell in the back end
  localparam int unsigned CycleLimit = 4000000;
  localparam int          PhaseItems = 180;

  // scoreboard: own copy of the configuration and the batch state
  class time_step_board;
    bit [17:0] gamma_q, gm1_q, courant_q;
    bit [16:0] cell_w_q;
    bit [63:0] min_step;
    bit        bad_seen;
    bit [17:0] exp_step[$];
    bit        exp_bad[$];
    int        errors;

    function new();
      gamma_q   = GammaRst;
      gm1_q     = GammaM1Rst;
      cell_w_q  = CellWRst;
      courant_q = CourantRst;
      min_step  = 64'(OneFix);
      bad_seen  = 1'b0;
      errors    = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [17:0] val);
      case (idx)
        RegGamma:   gamma_q   = val;
        RegGammaM1: gm1_q     = val;
        RegCellW:   cell_w_q  = val[16:0];
        RegCourant: courant_q = val;
        default: ;
      endcase
    endfunction

    // floor of the square root of a 128 bit value, two bits per step
    function bit [63:0] floor_sqrt(bit [127:0] v);
      bit [127:0] root, rem, trial;
      root = '0;
      rem  = '0;
      for (int k = 63; k >= 0; k--) begin
        rem   = (rem << 2) | 128'(v[2*k +: 2]);
        trial = (root << 2) | 128'd1;
        if (rem >= trial) begin
          rem  = rem - trial;
          root = (root << 1) | 128'd1;
        end else begin
          root = root << 1;
        end
      end
      return root[63:0];
    endfunction

    function void note_cell(logic signed [31:0] dens, logic signed [31:0] mom,
                            logic signed [31:0] ene, logic last);
      longint     rho, mo, en, inner;
      bit [63:0]  r, m, kin, p, uabs, s, a, wave, loc;
      rho = longint'(dens);
      mo  = longint'(mom);
      en  = longint'(ene);
      if (rho <= 0) begin
        bad_seen = 1'b1;
      end else begin
        r     = rho;
        m     = (mo < 0) ? -mo : mo;
        kin   = (m * m) / (2 * r);
        inner = en - longint'(kin);
        p     = (inner > 0) ? ((64'(gm1_q) * 64'(inner)) >> FracBits) : 64'd0;
        if (p == 0) begin
          bad_seen = 1'b1;
        end else begin
          uabs = (m << FracBits) / r;
          s    = (64'(gamma_q) * p) / r;
          a    = floor_sqrt({64'd0, s} << FracBits);
          wave = uabs + a;
          // zero wave speed counts as an infinite local step
          if (wave != 0) begin
            loc = (64'(cell_w_q) << FracBits) / wave;
            if (loc < min_step) min_step = loc;
          end
        end
      end
      if (last) begin
        exp_step.push_back(18'((64'(courant_q) * min_step) >> FracBits));
        exp_bad.push_back(bad_seen);
        min_step = 64'(OneFix);
        bad_seen = 1'b0;
      end
    endfunction

    function void check_step(logic [17:0] step, logic bad);
      bit [17:0] es;
      bit        eb;
      if (exp_step.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result step=%0d bad=%0b", step, bad);
        return;
      end
      es = exp_step.pop_front();
      eb = exp_bad.pop_front();
      if (step !== es || bad !== eb) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: step exp %0d got %0d, bad exp %0b got %0b", es, step, eb, bad);
      end
    endfunction

    function int pending();
      return exp_step.size();
    endfunction
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic signed [31:0] density_i = '0;
  logic signed [31:0] momentum_i = '0;
  logic signed [31:0] energy_i = '0;
  logic               last_cell_i = 1'b0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic [17:0]        time_step_out_o;
  logic               bad_cell_seen_o;
  logic               cfg_we_i = 1'b0;
  logic [1:0]         cfg_idx_i = '0;
  logic [17:0]        cfg_data_i = '0;

  time_step_board board = new();
  bit             no_idle = 1'b0;   // last part of the run, both sides steady
  bit             hold_req = 1'b0;  // asks the receiver for one long hold-off
  int unsigned    cycle_count = 0;

  cfl_global_time_step_unit dut (.*);

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // result check, pre-edge values of the handshake
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      board.check_step(time_step_out_o, bad_cell_seen_o);
  end

  // receiver: random bursts of back-pressure, one long hold-off on request
  initial begin
    @(posedge clk_i);
    forever begin
      if (hold_req) begin
        out_ready_i <= 1'b0;
        repeat (LongHold) @(posedge clk_i);
        hold_req = 1'b0;
      end else if (!no_idle && $urandom_range(0, 5) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  // one register write; the block is idle whenever this is called
  task automatic write_reg(logic [1:0] idx, logic [17:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    board.set_reg(idx, val);
  endtask

  // offers one cell transaction and waits for it to be taken
  task automatic send_cell(logic signed [31:0] d, logic signed [31:0] m,
                           logic signed [31:0] e, logic last);
    if (!no_idle && $urandom_range(0, 7) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    density_i   <= d;
    momentum_i  <= m;
    energy_i    <= e;
    last_cell_i <= last;
    do @(posedge clk_i); while (!in_ready_o);
    board.note_cell(d, m, e, last);
  endtask

  // sender pause until every result has come, then past the back end latency
  task automatic drain();
    in_valid_i <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
  endtask

  task automatic set_config(logic [17:0] g, logic [17:0] gm1, logic [17:0] cw,
                            logic [17:0] cfl);
    write_reg(RegGamma, g);
    write_reg(RegGammaM1, gm1);
    write_reg(RegCellW, cw);
    write_reg(RegCourant, cfl);
  endtask

  // mostly physical cells with random content, some noise and broken cells
  task automatic random_cell(output logic signed [31:0] d, output logic signed [31:0] m,
                             output logic signed [31:0] e);
    int     mode;
    longint r, mm, kin, en;
    mode = $urandom_range(0, 19);
    if (mode < 2) begin
      d = $urandom;
      m = $urandom;
      e = $urandom;
    end else if (mode == 2) begin
      d = $urandom_range(0, 1) ? 32'sd0 : ($urandom | 32'h8000_0000);
      m = $urandom;
      e = $urandom;
    end else begin
      r   = longint'($urandom_range(1 << 10, 1 << 22));
      mm  = longint'($urandom_range(0, 1 << 22));
      kin = (mm * mm) / (2 * r);
      if (mode == 3) en = kin - longint'($urandom_range(0, 100));   // pressure near zero
      else           en = kin + longint'($urandom_range(1, 1 << 22));
      if (en > 64'sh7FFF_FFFF) en = 64'sh7FFF_FFFF;
      d = 32'(r);
      m = 32'($urandom_range(0, 1) ? -mm : mm);
      e = 32'(en);
    end
  endtask

  task automatic random_phase(bit every_last);
    logic signed [31:0] d, m, e;
    int                 n, left;
    bit                 last;
    n    = 0;
    left = $urandom_range(1, 30);
    while (n < PhaseItems || !last) begin
      random_cell(d, m, e);
      left--;
      last = every_last || (left == 0);
      if (left == 0) left = $urandom_range(1, 30);
      send_cell(d, m, e, last);
      n++;
    end
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed cells under reset settings
    send_cell(32'sd0, 32'sd0, 32'sd65536, 1'b0);                // zero density
    send_cell(-32'sd1, 32'sd0, 32'sd65536, 1'b1);               // negative density, bad last
    send_cell(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 1'b1);
    send_cell(32'sd65536, 32'sd0, 32'sd163840, 1'b1);           // fluid at rest
    send_cell(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 1'b0);
    send_cell(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b1);
    send_cell(32'sd65536, 32'sd65536, 32'sd32768, 1'b1);        // energy equal to kinetic
    send_cell(32'sd65536, 32'sd0, 32'sh8000_0000, 1'b1);        // negative energy
    send_cell(32'sh7FFF_FFFF, 32'sd0, 32'sd3, 1'b1);            // zero wave speed
    send_cell(32'sd65536, 32'sd65536, 32'sd1, 1'b0);            // pressure fails, then good
    send_cell(32'sd65536, 32'sd6554, 32'sd163840, 1'b0);
    send_cell(32'sd8192, -32'sd65536, 32'sd655360, 1'b1);
    send_cell(32'sd1, 32'sd1, 32'sd1, 1'b1);
    drain();

    // zero gamma: sound speed vanishes, a cell at rest has zero wave speed
    set_config(18'd0, 18'd26214, 18'd655, 18'd52429);
    send_cell(32'sd65536, 32'sd0, 32'sd163840, 1'b1);
    send_cell(32'sd65536, 32'sd100, 32'sd163840, 1'b1);
    random_phase(1'b0);
    drain();

    // zero cell width gives a zero local step
    set_config(18'd91750, 18'd26214, 18'd0, 18'd131072);
    send_cell(32'sd65536, 32'sd100, 32'sd163840, 1'b1);
    random_phase(1'b0);
    drain();

    // smallest and largest settings of the nominal ranges
    set_config(18'd65536, 18'd1, 18'd1, 18'd1);
    random_phase(1'b0);
    drain();
    set_config(18'd196608, 18'd131072, 18'd65536, 18'd131072);
    random_phase(1'b0);
    drain();

    // long receiver hold-off while every cell closes a batch
    set_config(18'($urandom_range(65536, 196608)), 18'($urandom_range(1, 131072)),
               18'($urandom_range(1, 65536)), 18'($urandom_range(1, 131072)));
    hold_req = 1'b1;
    random_phase(1'b1);
    drain();

    for (int ph = 0; ph < 2; ph++) begin
      set_config(18'($urandom_range(65536, 196608)), 18'($urandom_range(1, 131072)),
                 18'($urandom_range(1, 65536)), 18'($urandom_range(1, 131072)));
      random_phase(1'b0);
      drain();
    end

    // final part at full rate on both sides
    set_config(18'd91750, 18'd26214, 18'd655, 18'd52429);
    no_idle = 1'b1;
    random_phase(1'b0);
    drain();

    if (board.errors == 0 && board.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
